[sv/lpmd_pkg.sv]
`default_nettype none
package lpmd_pkg;

    localparam int unsigned LEN_W     = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 16'd17;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 16'd512;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;

    typedef enum logic [1:0] {
        PH_HIGH    = 2'd0,
        PH_LOW     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_STUCK   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              new_session;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              first_of_message;
        logic              last_of_message;
        logic [LEN_W-1:0]  message_length;
        logic              length_error;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0] min_length;
        logic [LEN_W-1:0] max_length;
    } t_cfg;

endpackage
`default_nettype wire

[sv/lpmd_if.sv]
`default_nettype none
interface lpmd_in_if;
    import lpmd_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface lpmd_out_if;
    import lpmd_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

[sv/length_prefixed_message_deframer.sv]
// path: a byte passes the input register, then the framing update to the output register
// throughput: one byte per cycle unless the output stalls, set by the combinational framing
//   update; dropped bytes and high length bytes give no result, low ones only a length error
// reset: synchronous active-low i_rst_n clears framing to awaiting the high length byte,
//   empties both registers and loads min_length 17 and max_length 512
`default_nettype none
module length_prefixed_message_deframer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lpmd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lpmd_pkg::LEN_W-1:0]     i_cfg_data,
    lpmd_in_if.sink                             i_in,
    lpmd_out_if.source                          o_out
);
    import lpmd_pkg::*;

    t_cfg      cfg;
    lpmd_in_if in_q ();

    lpmd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lpmd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_in    (in_q.source)
    );

    lpmd_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (in_q.sink),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

[sv/lpmd_cfg_regs.sv]
`default_nettype none
module lpmd_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [lpmd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lpmd_pkg::LEN_W-1:0]         i_cfg_data,
    output lpmd_pkg::t_cfg                          o_cfg
);
    import lpmd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_length <= MIN_LENGTH_RST;
            r_cfg.max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            // indexes beyond the list are ignored
            if (i_cfg_idx == CFG_MIN_LENGTH) begin
                r_cfg.min_length <= i_cfg_data;
            end else if (i_cfg_idx == CFG_MAX_LENGTH) begin
                r_cfg.max_length <= i_cfg_data;
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[sv/lpmd_in_reg.sv]
`default_nettype none
module lpmd_in_reg (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lpmd_in_if.sink     i_in,
    lpmd_in_if.source   o_in
);
    import lpmd_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || o_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.item;
        end
    end

    assign o_in.valid = r_valid;
    assign o_in.item  = r_item;

endmodule
`default_nettype wire

[sv/lpmd_framer.sv]
`default_nettype none
module lpmd_framer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire lpmd_pkg::t_cfg i_cfg,
    lpmd_in_if.sink     i_in,
    lpmd_out_if.source  o_out
);
    import lpmd_pkg::*;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [BYTE_W-1:0] r_len_hi;
    logic [BYTE_W-1:0] n_len_hi;
    logic [LEN_W-1:0]  r_cur_len;
    logic [LEN_W-1:0]  n_cur_len;
    logic [LEN_W-1:0]  r_remaining;
    logic [LEN_W-1:0]  n_remaining;

    logic              r_out_valid;
    t_out_item         r_out_item;
    t_out_item         n_out_item;
    logic              has_result;

    t_phase            cur_phase;
    logic [BYTE_W-1:0] cur_len_hi;
    logic [LEN_W-1:0]  cur_len;
    logic [LEN_W-1:0]  cur_rem;
    logic [LEN_W-1:0]  decl_len;
    logic              len_bad;
    logic              rem_last;
    logic              consume;

    assign consume     = i_in.valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_out_valid || o_out.ready;

    // new session clears framing before the byte is parsed
    always_comb begin
        if (i_in.item.new_session) begin
            cur_phase  = PH_HIGH;
            cur_len_hi = '0;
            cur_len    = '0;
            cur_rem    = '0;
        end else begin
            cur_phase  = r_phase;
            cur_len_hi = r_len_hi;
            cur_len    = r_cur_len;
            cur_rem    = r_remaining;
        end
    end

    assign decl_len = {cur_len_hi, i_in.item.data_byte};
    assign len_bad  = (decl_len < i_cfg.min_length) || (decl_len > i_cfg.max_length);
    assign rem_last = (cur_rem <= 16'd1);

    // next state
    always_comb begin
        n_phase     = cur_phase;
        n_len_hi    = cur_len_hi;
        n_cur_len   = cur_len;
        n_remaining = cur_rem;
        unique case (cur_phase)
            PH_HIGH: begin
                n_len_hi = i_in.item.data_byte;
                n_phase  = PH_LOW;
            end
            PH_LOW: begin
                n_cur_len = decl_len;
                if (len_bad) begin
                    n_phase     = PH_STUCK;
                    n_remaining = '0;
                end else begin
                    n_remaining = decl_len;
                    n_phase     = (decl_len == '0) ? PH_HIGH : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (rem_last) begin
                    n_remaining = '0;
                    n_phase     = PH_HIGH;
                end else begin
                    n_remaining = cur_rem - 16'd1;
                end
            end
            PH_STUCK: begin
                n_phase = PH_STUCK;
            end
        endcase
    end

    // result of this byte
    always_comb begin
        has_result = 1'b0;
        n_out_item = '0;
        unique case (cur_phase)
            PH_HIGH: begin
                has_result = 1'b0;
            end
            PH_LOW: begin
                has_result                = len_bad;
                n_out_item.message_length = decl_len;
                n_out_item.length_error   = 1'b1;
            end
            PH_PAYLOAD: begin
                has_result                  = 1'b1;
                n_out_item.payload_byte     = i_in.item.data_byte;
                n_out_item.first_of_message = (cur_rem == cur_len);
                n_out_item.last_of_message  = rem_last;
                n_out_item.message_length   = cur_len;
            end
            PH_STUCK: begin
                has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HIGH;
            r_len_hi    <= '0;
            r_cur_len   <= '0;
            r_remaining <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (consume) begin
                r_phase     <= n_phase;
                r_len_hi    <= n_len_hi;
                r_cur_len   <= n_cur_len;
                r_remaining <= n_remaining;
                r_out_valid <= has_result;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && has_result) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import lpmd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 6;

    // indexes the block decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [LEN_W-1:0]     cfg_data;

    lpmd_in_if  in_ch ();
    lpmd_out_if out_ch ();

    length_prefixed_message_deframer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // framing tracker state and limits as the block should hold them
    t_phase           fr_phase;
    logic [7:0]       fr_len_hi;
    logic [LEN_W-1:0] fr_cur_len;
    logic [LEN_W-1:0] fr_remaining;
    logic [LEN_W-1:0] lim_min;
    logic [LEN_W-1:0] lim_max;

    t_out_item pending_results[$];

    bit          pace_on;
    int unsigned n_sent;
    int unsigned n_mismatch   = 0;
    int unsigned n_payload    = 0;
    int unsigned n_messages   = 0;
    int unsigned n_len_errors = 0;
    int unsigned n_settings;
    int unsigned cycles       = 0;
    int unsigned out_stall;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t after %0d cycles", $time, cycles);
            $display("[length_prefixed_message_deframer] ERROR");
            $finish;
        end
    end

    function automatic void deframe_predict(t_in_item it);
        t_out_item        res;
        logic [LEN_W-1:0] len;
        res = '0;
        if (it.new_session) begin
            fr_phase     = PH_HIGH;
            fr_len_hi    = '0;
            fr_cur_len   = '0;
            fr_remaining = '0;
        end
        case (fr_phase)
            PH_HIGH: begin
                fr_len_hi = it.data_byte;
                fr_phase  = PH_LOW;
            end
            PH_LOW: begin
                len        = {fr_len_hi, it.data_byte};
                fr_cur_len = len;
                if (len < lim_min || len > lim_max) begin
                    fr_phase           = PH_STUCK;
                    fr_remaining       = '0;
                    res.message_length = len;
                    res.length_error   = 1'b1;
                    pending_results.push_back(res);
                end else begin
                    fr_remaining = len;
                    fr_phase     = (len == 0) ? PH_HIGH : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                res.payload_byte     = it.data_byte;
                res.first_of_message = (fr_remaining == fr_cur_len);
                res.last_of_message  = (fr_remaining <= 1);
                res.message_length   = fr_cur_len;
                pending_results.push_back(res);
                if (fr_remaining <= 1) begin
                    fr_remaining = '0;
                    fr_phase     = PH_HIGH;
                end else begin
                    fr_remaining = fr_remaining - 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_field(input string field, input logic [15:0] exp_v,
                                input logic [15:0] got_v);
        n_mismatch++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
    endtask

    // output side: random back-pressure and the result check
    always @(posedge clk) begin
        t_out_item got;
        t_out_item exp_r;
        if (!rst_n) begin
            out_stall = 0;
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.item;
                if (pending_results.size() == 0) begin
                    n_mismatch++;
                    $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got.payload_byte !== exp_r.payload_byte)
                        report_field("payload_byte", 16'(exp_r.payload_byte),
                                     16'(got.payload_byte));
                    if (got.first_of_message !== exp_r.first_of_message)
                        report_field("first_of_message", 16'(exp_r.first_of_message),
                                     16'(got.first_of_message));
                    if (got.last_of_message !== exp_r.last_of_message)
                        report_field("last_of_message", 16'(exp_r.last_of_message),
                                     16'(got.last_of_message));
                    if (got.message_length !== exp_r.message_length)
                        report_field("message_length", exp_r.message_length,
                                     got.message_length);
                    if (got.length_error !== exp_r.length_error)
                        report_field("length_error", 16'(exp_r.length_error),
                                     16'(got.length_error));
                    if (exp_r.length_error)
                        n_len_errors++;
                    else
                        n_payload++;
                    if (exp_r.last_of_message)
                        n_messages++;
                end
                out_stall = pace_on ? $urandom_range(0, 5) : 0;
            end else if (out_stall > 0) begin
                out_stall--;
            end
            out_ch.ready <= (out_stall == 0);
        end
    end

    // valid stays up between back-to-back transactions
    task automatic send_byte(input logic [7:0] b, input logic ns);
        int unsigned gap;
        t_in_item    it;
        gap            = pace_on ? $urandom_range(0, 5) : 0;
        it.data_byte   = b;
        it.new_session = ns;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        do @(posedge clk); while (!in_ch.ready);
        if (ns || fr_phase != PH_STUCK)
            n_sent++;
        deframe_predict(it);
    endtask

    task automatic send_header(input logic [15:0] len, input logic ns);
        send_byte(len[15:8], ns);
        send_byte(len[7:0], 1'b0);
    endtask

    task automatic wait_idle;
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == CFG_MIN_LENGTH)
            lim_min = val;
        else if (idx == CFG_MAX_LENGTH)
            lim_max = val;
    endtask

    task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi, input bit spare);
        write_reg(CFG_MIN_LENGTH, lo);
        if (spare) begin
            write_reg(CFG_SPARE_A, 16'($urandom_range(0, 65535)));
            write_reg(CFG_SPARE_B, 16'hFFFF);
        end
        write_reg(CFG_MAX_LENGTH, hi);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic test_reset_limits;
        send_header(16'd16, 1'b0);      // one below reset minimum
        send_byte(8'hFF, 1'b0);         // dropped while stuck
        send_header(16'd513, 1'b1);     // one above reset maximum
        wait_idle();
    endtask

    task automatic test_short_limits;
        set_limits(16'd0, 16'd2, 1'b1);
        send_header(16'd0, 1'b1);       // empty message, no result
        send_header(16'd2, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_header(16'd1, 1'b0);       // first and last on one byte
        send_byte(8'h80, 1'b0);
        send_header(16'd3, 1'b0);
        wait_idle();
    endtask

    task automatic test_crossed_limits;
        set_limits(16'hFFFF, 16'd0, 1'b0);
        send_header(16'hFFFF, 1'b1);
        send_header(16'd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_mid_message_restart;
        set_limits(16'd0, 16'hFFFF, 1'b0);
        send_header(16'd3, 1'b1);
        send_byte(8'h11, 1'b0);
        send_header(16'd1, 1'b1);       // restart cuts the open message
        send_byte(8'h22, 1'b0);
        wait_idle();
    endtask

    task automatic pick_limits;
        int unsigned a;
        case ($urandom_range(0, 7))
            0: set_limits(MIN_LENGTH_RST, MAX_LENGTH_RST, $urandom_range(0, 2) == 0);
            1: set_limits(16'd0, 16'($urandom_range(0, 40)), $urandom_range(0, 2) == 0);
            2: begin
                a = $urandom_range(0, 40);
                set_limits(16'(a), 16'(a + $urandom_range(0, 20)), $urandom_range(0, 2) == 0);
            end
            3: set_limits(16'd0, 16'hFFFF, $urandom_range(0, 2) == 0);
            4: set_limits(16'hFFFF, 16'hFFFF, $urandom_range(0, 2) == 0);
            5: begin
                a = $urandom_range(1, 65535);
                set_limits(16'(a), 16'($urandom_range(0, a - 1)), $urandom_range(0, 2) == 0);
            end
            6: begin
                a = $urandom_range(1, 30);
                set_limits(16'(a), 16'(a), $urandom_range(0, 2) == 0);
            end
            default: set_limits(16'd0, 16'd0, $urandom_range(0, 2) == 0);
        endcase
    endtask

    task automatic test_random_traffic;
        int unsigned goal;
        int unsigned phase_end;
        int unsigned kind;
        int unsigned len;
        int unsigned top;
        int unsigned cnt;
        bit          restart;
        bit          bad_ok;
        goal = n_sent + 1500;
        while (n_sent < goal) begin
            pick_limits();
            restart   = 1'b1;
            phase_end = n_sent + 150;
            while (n_sent < phase_end) begin
                pace_on = ($urandom_range(0, 3) != 0);
                kind    = $urandom_range(0, 9);
                if (kind < 7 && lim_min <= lim_max && lim_min <= 64) begin
                    top = (lim_max < lim_min + 24) ? lim_max : lim_min + 24;
                    len = $urandom_range(lim_min, top);
                    cnt = (kind == 6 && len > 0) ? $urandom_range(0, len - 1) : len;
                    send_header(16'(len), restart || $urandom_range(0, 9) == 0);
                    repeat (cnt) send_byte(8'($urandom_range(0, 255)), 1'b0);
                    restart = (cnt != len);
                end else if (kind < 9) begin
                    // declared length outside the window, then bytes that must be dropped
                    bad_ok = 1'b1;
                    if (lim_min > lim_max)
                        len = $urandom_range(0, 65535);
                    else if (lim_min > 0 && (lim_max == 16'hFFFF || $urandom_range(0, 1)))
                        len = $urandom_range(0, lim_min - 1);
                    else if (lim_max < 16'hFFFF)
                        len = $urandom_range(lim_max + 1, 65535);
                    else
                        bad_ok = 1'b0;
                    if (bad_ok) begin
                        send_header(16'(len), restart);
                        repeat ($urandom_range(0, 3))
                            send_byte(8'($urandom_range(0, 255)), 1'b0);
                        restart = 1'b1;
                    end
                end else begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    restart = 1'b1;
                end
            end
            pace_on = 1'b1;
            wait_idle();
        end
    endtask

    initial begin
        n_sent       = 0;
        n_settings   = 1;
        pace_on      = 1'b1;
        fr_phase     = PH_HIGH;
        fr_len_hi    = '0;
        fr_cur_len   = '0;
        fr_remaining = '0;
        lim_min      = MIN_LENGTH_RST;
        lim_max      = MAX_LENGTH_RST;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.item   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_limits();
        test_short_limits();
        test_crossed_limits();
        test_mid_message_restart();
        test_random_traffic();

        $display("sent %0d stream bytes over %0d limit settings", n_sent, n_settings);
        $display("checked %0d payload bytes, %0d complete messages, %0d length errors",
                 n_payload, n_messages, n_len_errors);
        if (n_mismatch == 0) begin
            $display("[length_prefixed_message_deframer] OK");
        end else begin
            $display("[length_prefixed_message_deframer] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
sv/lpmd_pkg.sv
sv/lpmd_if.sv
sv/lpmd_cfg_regs.sv
sv/lpmd_in_reg.sv
sv/lpmd_framer.sv
sv/length_prefixed_message_deframer.sv
tb/tb.sv
